// ===== sv/dpe_pkg.sv =====
// ----------------------------------------------------------------------------
// dpe_pkg: shared types and constants of the dual postfix evaluator
// Symbol codes, operator decode, cell select codes, sequencer states and divider status.
// ----------------------------------------------------------------------------
package dpe_pkg;

  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_ZERO = 8'h30;

  typedef enum logic [2:0] {
    OP_NUM,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // What a storage cell loads on the next edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_FROM_NEXT2
  } cell_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPER,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  // Divider status handed back to the sequencer.
  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_status_t;

  function automatic op_t decode_op(input logic [7:0] s);
    op_t op;
    case (s)
      SYM_ADD: op = OP_ADD;
      SYM_SUB: op = OP_SUB;
      SYM_MUL: op = OP_MUL;
      SYM_DIV: op = OP_DIV;
      default: op = OP_NUM;
    endcase
    return op;
  endfunction

endpackage

// ===== sv/dpe_if.sv =====
// ----------------------------------------------------------------------------
// dpe interfaces: input and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface dpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface dpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] stack_value;
  logic signed [31:0] queue_value;
  logic               stack_error;
  logic               queue_error;
  logic               agree;
  modport source (output valid, output stack_value, output queue_value,
                  output stack_error, output queue_error, output agree,
                  input ready);
  modport sink   (input valid, input stack_value, input queue_value,
                  input stack_error, input queue_error, input agree,
                  output ready);
endinterface

// ===== sv/dpe_cell.sv =====
// ----------------------------------------------------------------------------
// dpe_cell: one storage cell of an operand chain
// Holds one 32-bit entry and takes a new value from itself, the load bus or
// a neighbor, as the chain control selects.
// ----------------------------------------------------------------------------
module dpe_cell (
  input  logic              clk,
  input  dpe_pkg::cell_sel_t sel,
  input  logic [31:0]       load_data,
  input  logic [31:0]       prev,
  input  logic [31:0]       next,
  input  logic [31:0]       next2,
  output logic [31:0]       value
);

  logic [31:0] value_next;

  // Select the next entry.
  always_comb begin
    case (sel)
      dpe_pkg::CELL_LOAD:       value_next = load_data;
      dpe_pkg::CELL_FROM_PREV:  value_next = prev;
      dpe_pkg::CELL_FROM_NEXT:  value_next = next;
      dpe_pkg::CELL_FROM_NEXT2: value_next = next2;
      default:                  value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== sv/dpe_divider.sv =====
// ----------------------------------------------------------------------------
// dpe_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// toward zero. A zero divisor is detected by the caller.
// ----------------------------------------------------------------------------
module dpe_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           dividend,
  input  logic [31:0]           divisor,
  output dpe_pkg::div_status_t  status
);

  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] mag_b;
  logic [32:0] rem_sh;
  logic [32:0] trial;

  // One restoring step.
  assign rem_sh = {rem, quo[31]};
  assign trial  = rem_sh - {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt  <= cnt - 6'd1;
      busy <= (cnt != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[31] ^ divisor[31];
      quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
      mag_b <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem   <= 32'd0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign status.busy     = busy;
  assign status.quotient = neg ? (32'd0 - quo) : quo;

endmodule

// ===== sv/dual_postfix_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// dual_postfix_evaluator_core: postfix evaluation on a stack and a queue
// Evaluates each expression twice, with a stack chain and a queue chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one expression character per transfer (symbol, last).
//   out_ch carries one result per expression, after the character with last.
//   Operands are held in two rows of cells; entries shift between cells, so
//   the top of the stack and the queue front always sit in cell 0.
//   A character is taken only in idle and decoded in the operator state;
//   + - and * then apply, / first waits in the divide state for the 32-step
//   iterative divider, and an operator that neither evaluator can apply
//   returns to idle; after the last character, emit fills the output register.
//   Reset clears the counts, the error flags and the output valid flag; the
//   cell contents need no clearing.
//   When the receiver stalls, the result waits in the output register and
//   the next expression is taken until its own last character, which then
//   waits for the register to drain.
// ----------------------------------------------------------------------------
module dual_postfix_evaluator_core #(
  parameter int STORE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  dpe_in_if.sink           in_ch,
  dpe_out_if.source        out_ch
);

  localparam int CW = $clog2(STORE_DEPTH + 1);

  dpe_pkg::state_t    state, state_next;
  logic [7:0]         sym;
  logic               last_r;
  dpe_pkg::op_t       op;
  logic [CW-1:0]      stack_count;
  logic [CW-1:0]      queue_count;
  logic               stack_failed;
  logic               queue_failed;
  logic               s_act, q_act;
  logic [31:0]        res_s, res_q;
  logic [31:0]        res_s_next, res_q_next;
  logic [31:0]        operand;
  logic [31:0]        s_load, q_load;
  logic               s_push, q_push;
  logic               s_act_next, q_act_next;
  logic               s_fail_now, q_fail_now;
  logic               div_start;
  dpe_pkg::div_status_t s_div, q_div;
  logic               emit_ok;
  logic               se, qe;
  logic [31:0]        sv, qv;

  logic [31:0]        s_val [STORE_DEPTH];
  logic [31:0]        q_val [STORE_DEPTH];
  dpe_pkg::cell_sel_t s_sel [STORE_DEPTH];
  dpe_pkg::cell_sel_t q_sel [STORE_DEPTH];

  assign op      = dpe_pkg::decode_op(sym);
  assign operand = {24'd0, sym} - {24'd0, dpe_pkg::SYM_ZERO};
  assign emit_ok = !out_ch.valid || out_ch.ready;

  // Fault and action checks for the current character.
  always_comb begin
    s_act_next = 1'b0;
    q_act_next = 1'b0;
    s_push     = 1'b0;
    q_push     = 1'b0;
    s_fail_now = 1'b0;
    q_fail_now = 1'b0;
    if (!stack_failed) begin
      if (op != dpe_pkg::OP_NUM) begin
        if (stack_count < CW'(2)) s_fail_now = 1'b1;
        else                      s_act_next = 1'b1;
      end else if (stack_count == CW'(STORE_DEPTH)) begin
        s_fail_now = 1'b1;
      end else begin
        s_push = 1'b1;
      end
    end
    if (!queue_failed) begin
      if (op != dpe_pkg::OP_NUM) begin
        if (queue_count < CW'(2)) q_fail_now = 1'b1;
        else                      q_act_next = 1'b1;
      end else if (queue_count == CW'(STORE_DEPTH)) begin
        q_fail_now = 1'b1;
      end else begin
        q_push = 1'b1;
      end
    end
  end

  // Arithmetic on the two front entries; left operand in cell 1.
  always_comb begin
    case (op)
      dpe_pkg::OP_ADD: begin
        res_s_next = s_val[1] + s_val[0];
        res_q_next = q_val[1] + q_val[0];
      end
      dpe_pkg::OP_SUB: begin
        res_s_next = s_val[1] - s_val[0];
        res_q_next = q_val[1] - q_val[0];
      end
      dpe_pkg::OP_MUL: begin
        res_s_next = s_val[1] * s_val[0];
        res_q_next = q_val[1] * q_val[0];
      end
      default: begin
        res_s_next = 32'd0;
        res_q_next = 32'd0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dpe_pkg::ST_IDLE:
        if (in_ch.valid) state_next = dpe_pkg::ST_OPER;
      dpe_pkg::ST_OPER:
        if (s_act_next || q_act_next)
          state_next = (op == dpe_pkg::OP_DIV) ? dpe_pkg::ST_DIV : dpe_pkg::ST_APPLY;
        else
          state_next = last_r ? dpe_pkg::ST_EMIT : dpe_pkg::ST_IDLE;
      dpe_pkg::ST_DIV:
        if (!s_div.busy && !q_div.busy) state_next = dpe_pkg::ST_APPLY;
      dpe_pkg::ST_APPLY:
        state_next = last_r ? dpe_pkg::ST_EMIT : dpe_pkg::ST_IDLE;
      dpe_pkg::ST_EMIT:
        if (emit_ok) state_next = dpe_pkg::ST_IDLE;
      default:
        state_next = dpe_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = (state == dpe_pkg::ST_IDLE);
    div_start   = (state == dpe_pkg::ST_OPER) && (op == dpe_pkg::OP_DIV);
  end

  // Load value: result of the pending operator in apply, else the operand.
  assign s_load = (state == dpe_pkg::ST_APPLY) ?
                  ((op == dpe_pkg::OP_DIV) ? s_div.quotient : res_s) : operand;
  assign q_load = (state == dpe_pkg::ST_APPLY) ?
                  ((op == dpe_pkg::OP_DIV) ? q_div.quotient : res_q) : operand;

  // Cell controls: stack top and queue front sit in cell 0.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      s_sel[i] = dpe_pkg::CELL_HOLD;
      q_sel[i] = dpe_pkg::CELL_HOLD;
      if (state == dpe_pkg::ST_OPER) begin
        if (s_push) s_sel[i] = (i == 0) ? dpe_pkg::CELL_LOAD : dpe_pkg::CELL_FROM_PREV;
        if (q_push && CW'(i) == queue_count) q_sel[i] = dpe_pkg::CELL_LOAD;
      end else if (state == dpe_pkg::ST_APPLY) begin
        if (s_act && !(op == dpe_pkg::OP_DIV && s_val[0] == 32'd0))
          s_sel[i] = (i == 0) ? dpe_pkg::CELL_LOAD : dpe_pkg::CELL_FROM_NEXT;
        if (q_act && !(op == dpe_pkg::OP_DIV && q_val[0] == 32'd0))
          q_sel[i] = (CW'(i) == queue_count - CW'(2)) ? dpe_pkg::CELL_LOAD
                                                       : dpe_pkg::CELL_FROM_NEXT2;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dpe_pkg::ST_IDLE;
      stack_count  <= '0;
      queue_count  <= '0;
      stack_failed <= 1'b0;
      queue_failed <= 1'b0;
      s_act        <= 1'b0;
      q_act        <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dpe_pkg::ST_EMIT && emit_ok) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        dpe_pkg::ST_OPER: begin
          s_act <= s_act_next;
          q_act <= q_act_next;
          if (s_fail_now) stack_failed <= 1'b1;
          if (q_fail_now) queue_failed <= 1'b1;
          if (s_push) stack_count <= stack_count + CW'(1);
          if (q_push) queue_count <= queue_count + CW'(1);
        end
        dpe_pkg::ST_APPLY: begin
          if (s_act) begin
            if (op == dpe_pkg::OP_DIV && s_val[0] == 32'd0) stack_failed <= 1'b1;
            else stack_count <= stack_count - CW'(1);
          end
          if (q_act) begin
            if (op == dpe_pkg::OP_DIV && q_val[0] == 32'd0) queue_failed <= 1'b1;
            else queue_count <= queue_count - CW'(1);
          end
        end
        dpe_pkg::ST_EMIT: begin
          if (emit_ok) begin
            stack_count  <= '0;
            queue_count  <= '0;
            stack_failed <= 1'b0;
            queue_failed <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sym    <= in_ch.symbol;
      last_r <= in_ch.last;
    end
    if (state == dpe_pkg::ST_OPER) begin
      res_s <= res_s_next;
      res_q <= res_q_next;
    end
  end

  // Result fields.
  assign se = stack_failed || (stack_count == '0);
  assign qe = queue_failed || (queue_count == '0);
  assign sv = se ? 32'd0 : s_val[0];
  assign qv = qe ? 32'd0 : q_val[0];

  always_ff @(posedge clk) begin
    if (state == dpe_pkg::ST_EMIT && emit_ok) begin
      out_ch.stack_value <= sv;
      out_ch.queue_value <= qv;
      out_ch.stack_error <= se;
      out_ch.queue_error <= qe;
      out_ch.agree       <= (se && qe) || (!se && !qe && sv == qv);
    end
  end

  // Operand chains.
  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cells
    logic [31:0] s_prev, s_nx, s_nx2, q_prev, q_nx, q_nx2;
    if (g > 0) begin : g_p
      assign s_prev = s_val[g-1];
      assign q_prev = q_val[g-1];
    end else begin : g_p0
      assign s_prev = 32'd0;
      assign q_prev = 32'd0;
    end
    if (g + 1 < STORE_DEPTH) begin : g_n
      assign s_nx = s_val[g+1];
      assign q_nx = q_val[g+1];
    end else begin : g_n0
      assign s_nx = 32'd0;
      assign q_nx = 32'd0;
    end
    if (g + 2 < STORE_DEPTH) begin : g_n2
      assign s_nx2 = s_val[g+2];
      assign q_nx2 = q_val[g+2];
    end else begin : g_n20
      assign s_nx2 = 32'd0;
      assign q_nx2 = 32'd0;
    end
    dpe_cell u_s_cell (
      .clk(clk), .sel(s_sel[g]), .load_data(s_load),
      .prev(s_prev), .next(s_nx), .next2(s_nx2), .value(s_val[g])
    );
    dpe_cell u_q_cell (
      .clk(clk), .sel(q_sel[g]), .load_data(q_load),
      .prev(q_prev), .next(q_nx), .next2(q_nx2), .value(q_val[g])
    );
  end

  // Dividers, one per evaluator.
  dpe_divider u_s_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(s_val[1]), .divisor(s_val[0]), .status(s_div)
  );
  dpe_divider u_q_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(q_val[1]), .divisor(q_val[0]), .status(q_div)
  );

  // Checks.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CW'(STORE_DEPTH)) else $error("stack count beyond depth");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= CW'(STORE_DEPTH)) else $error("queue count beyond depth");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.stack_error |-> out_ch.stack_value == 32'd0)
    else $error("stack error with nonzero value");
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == dpe_pkg::ST_EMIT)
    else $error("result raised outside emit");

endmodule
